FILE: design/rhc_pkg.sv
// rhc_pkg: shared types, constants and the divider step for the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  localparam int unsigned HUE_SIXTH = 3840;   // 60 degrees in 1/64 degree units
  localparam int unsigned HUE_FULL  = 23040;  // 360 degrees
  localparam int unsigned SAT_ONE   = 4096;   // 1.0 in Q12

  localparam int unsigned CH_W      = 8;
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned SAT_W     = 13;
  localparam int unsigned NUM_W     = 21;     // 2*N*x + d, up to ~1.96M
  localparam int unsigned DEN_W     = CH_W + 1;
  localparam int unsigned QUO_W     = 13;     // both quotients stay below 2^13
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned HSUM_W    = 17;     // signed hue before wrap

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    sector_t           sec;
    logic              neg;     // difference term is negative
    logic              grey;    // delta == 0
    logic              black;   // max == 0
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   alpha;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0]       rem;
    logic [QUO_W-1:0]       nlo;   // numerator bits not yet consumed
    logic [QUO_W-1:0]       quo;
    logic [DEN_W-1:0]       den;
  } div_lane_t;

  typedef struct packed {
    div_lane_t hue;
    div_lane_t sat;
    side_t     side;
  } div_word_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness;
    logic [CH_W-1:0]  alpha;
  } hsv_t;

  // One restoring division step: brings down the next numerator bit.
  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t       n;
    logic [DEN_W:0]  sh;
    logic            qb;
    sh = {l.rem, l.nlo[QUO_W-1]};
    qb = (sh >= {1'b0, l.den});
    n.rem = qb ? DEN_W'(sh - {1'b0, l.den}) : sh[DEN_W-1:0];
    n.nlo = {l.nlo[QUO_W-2:0], 1'b0};
    n.quo = {l.quo[QUO_W-2:0], qb};
    n.den = l.den;
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: design/rgb_to_hsv_converter.sv
// rgb_to_hsv_converter: top level, RGBA pixel stream in, HSV fixed-point stream out.
// Depends on rhc_pkg, rhc_front, rhc_div, rhc_back.
//
// Usage:
//   Input channel in_*: one RGBA pixel per word, accepted when in_tvalid and
//   in_tready are both high. Output channel out_*: one HSV word per pixel, in
//   order. Hue is in 1/64 degree units (0..23039), saturation is Q12
//   (0..4096), brightness is the max channel byte, alpha is copied.
//   Stages: two front stages, 13 divider stages, one output register.
//   Throughput: one pixel per cycle while out_tready is high; both
//   quotients are found by a 13-stage restoring divider, one quotient bit per stage.
//   Reset (rst_n low, synchronous) empties the pipeline; no words are in
//   flight afterwards. When the receiver holds out_tready low, each stage
//   keeps its word and ready fills the empty stages behind it, so up to 16
//   words are buffered before in_tready drops. Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter
  import rhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // hue[14:0], saturation[27:15], brightness[35:28],
                                       // alpha_out[43:36], zero[47:44]
);

  logic      f_valid, f_ready, d_valid, d_ready;
  div_word_t f_word, d_word;
  hsv_t      pix;

  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .alpha     (in_tdata[31:24]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_word  (f_word)
  );

  rhc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_word  (d_word)
  );

  rhc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_word   (d_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (pix)
  );

  assign out_tdata = {4'b0, pix.alpha, pix.brightness, pix.saturation, pix.hue};

endmodule

`default_nettype wire

FILE: design/rhc_front.sv
// rhc_front: two pipeline stages; max/min/sector select, then divider operand setup.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_front
  import rhc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CH_W-1:0] red,
  input  wire logic [CH_W-1:0] green,
  input  wire logic [CH_W-1:0] blue,
  input  wire logic [CH_W-1:0] alpha,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output div_word_t            out_word
);

  // stage A
  logic            a_valid_r;
  logic [CH_W-1:0] a_mx_r, a_mn_r, a_red_r, a_green_r, a_blue_r, a_alpha_r;
  sector_t         a_sec_r;
  logic            a_ready;
  logic [CH_W-1:0] a_mx_nxt, a_mn_nxt;
  sector_t         a_sec_nxt;

  // stage B
  logic            b_valid_r;
  div_word_t       b_word_r, b_word_nxt;
  logic            b_ready;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    if (red >= green && red >= blue) begin
      a_sec_nxt = SEC_RED;
      a_mx_nxt  = red;
    end else if (green >= blue) begin
      a_sec_nxt = SEC_GREEN;
      a_mx_nxt  = green;
    end else begin
      a_sec_nxt = SEC_BLUE;
      a_mx_nxt  = blue;
    end
    a_mn_nxt = red;
    if (green < a_mn_nxt) a_mn_nxt = green;
    if (blue < a_mn_nxt) a_mn_nxt = blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_mx_r    <= a_mx_nxt;
      a_mn_r    <= a_mn_nxt;
      a_sec_r   <= a_sec_nxt;
      a_red_r   <= red;
      a_green_r <= green;
      a_blue_r  <= blue;
      a_alpha_r <= alpha;
    end
  end

  logic [CH_W-1:0] delta, mag;
  logic [CH_W:0]   diff;

  always_comb begin
    delta = a_mx_r - a_mn_r;
    case (a_sec_r)
      SEC_RED:   diff = {1'b0, a_green_r} - {1'b0, a_blue_r};
      SEC_GREEN: diff = {1'b0, a_blue_r} - {1'b0, a_red_r};
      SEC_BLUE:  diff = {1'b0, a_red_r} - {1'b0, a_green_r};
      default:   diff = '0;
    endcase
    mag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];

    // round(N*x/d) = floor((2*N*x + d) / (2*d))
    b_word_nxt.hue.rem = '0;
    b_word_nxt.hue.quo = '0;
    b_word_nxt.hue.den = {delta, 1'b0};
    {b_word_nxt.hue.rem[CH_W-1:0], b_word_nxt.hue.nlo} =
      NUM_W'(NUM_W'(mag) * NUM_W'(2 * HUE_SIXTH) + NUM_W'(delta));

    b_word_nxt.sat.rem = '0;
    b_word_nxt.sat.quo = '0;
    b_word_nxt.sat.den = {a_mx_r, 1'b0};
    {b_word_nxt.sat.rem[CH_W-1:0], b_word_nxt.sat.nlo} =
      {delta, QUO_W'(a_mx_r)};

    b_word_nxt.side.sec   = a_sec_r;
    b_word_nxt.side.neg   = diff[CH_W];
    b_word_nxt.side.grey  = (delta == '0);
    b_word_nxt.side.black = (a_mx_r == '0);
    b_word_nxt.side.mx    = a_mx_r;
    b_word_nxt.side.alpha = a_alpha_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_word_r <= b_word_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_word  = b_word_r;

endmodule

`default_nettype wire

FILE: design/rhc_div.sv
// rhc_div: pipelined restoring divider, one quotient bit per stage, hue and saturation
// lanes in lockstep. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_div
  import rhc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire div_word_t in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output div_word_t      out_word
);

  logic      valid_r [DIV_STEPS];
  div_word_t word_r  [DIV_STEPS];
  logic      src_valid [DIV_STEPS+1];
  div_word_t src_word  [DIV_STEPS+1];
  logic      ready     [DIV_STEPS+1];

  assign src_valid[0]      = in_valid;
  assign src_word[0]       = in_word;
  assign ready[DIV_STEPS]  = out_ready;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    div_word_t step_nxt;

    assign ready[k]       = !valid_r[k] || ready[k+1];
    assign src_valid[k+1] = valid_r[k];
    assign src_word[k+1]  = word_r[k];

    always_comb begin
      step_nxt      = src_word[k];
      step_nxt.hue  = div_step(src_word[k].hue);
      step_nxt.sat  = div_step(src_word[k].sat);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_r[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[k]) begin
        word_r[k] <= step_nxt;
      end
    end
  end

  assign in_ready  = ready[0];
  assign out_valid = src_valid[DIV_STEPS];
  assign out_word  = src_word[DIV_STEPS];

endmodule

`default_nettype wire

FILE: design/rhc_back.sv
// rhc_back: hue sector offset, sign and wrap, saturation, grey- and black-pixel handling;
// holds the output register. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_back
  import rhc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire div_word_t in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output hsv_t           out_pix
);

  logic               valid_r;
  hsv_t               pix_r, pix_nxt;
  logic signed [HSUM_W-1:0] off, hq, hsum;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    case (in_word.side.sec)
      SEC_RED:   off = '0;
      SEC_GREEN: off = HSUM_W'(2 * HUE_SIXTH);
      SEC_BLUE:  off = HSUM_W'(4 * HUE_SIXTH);
      default:   off = '0;
    endcase
    hq   = HSUM_W'(in_word.hue.quo);
    hsum = in_word.side.neg ? off - hq : off + hq;
    if (hsum < 0) hsum = hsum + HSUM_W'(HUE_FULL);
    if (hsum >= HSUM_W'(HUE_FULL)) hsum = hsum - HSUM_W'(HUE_FULL);

    pix_nxt.hue        = in_word.side.grey ? '0 : hsum[HUE_W-1:0];
    pix_nxt.saturation = in_word.side.black ? '0 : in_word.sat.quo;
    pix_nxt.brightness = in_word.side.mx;
    pix_nxt.alpha      = in_word.side.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pix   = pix_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !valid_r)
    else $error("output valid set after reset");
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
      valid_r |-> (pix_r.hue < HUE_W'(HUE_FULL)))
    else $error("hue out of range");
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
      valid_r |-> (pix_r.saturation <= SAT_W'(SAT_ONE)))
    else $error("saturation above one");
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
      (valid_r && pix_r.brightness == '0) |-> (pix_r.saturation == '0 && pix_r.hue == '0))
    else $error("black pixel with nonzero hue or saturation");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (valid_r && !out_ready) |=> (valid_r && $stable(pix_r)))
    else $error("stalled output word changed");

endmodule

`default_nettype wire

FILE: dv/tb_rgb_to_hsv_converter.sv
// tb_rgb_to_hsv_converter: self-checking bench for the RGB to HSV converter.
// Streams directed and random RGBA pixels with random idles and backpressure.
// Checks each HSV word against an in-bench fixed-point model. Needs rhc_pkg.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;
  import rhc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PIXELS = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // hue[14:0], saturation[27:15], brightness[35:28],
                                // alpha[43:36], zero[47:44]

  logic [31:0] pix_q[$];
  hsv_t        hsv_q[$];

  int  mismatches = 0;
  int  pixels_in = 0;
  int  words_out = 0;
  int  stall_cycles = 0;
  int  cycles = 0;
  int  directed_cnt = 0;
  int  in_gap = 0;
  int  rx_gap = 0;
  int  calm = 0;
  bit  in_taken = 1'b0;
  bit  hold_off = 1'b0;

  rgb_to_hsv_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic hsv_t to_hsv(input logic [31:0] pix);
    hsv_t res;
    int   r, g, b, mx, mn, delta, num, base, q, hue;
    r = int'(pix[7:0]);
    g = int'(pix[15:8]);
    b = int'(pix[23:16]);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    if (delta > 0) begin
      if (mx == r) begin
        base = 0;
        num = g - b;
      end else if (mx == g) begin
        base = 2 * int'(HUE_SIXTH);
        num = b - r;
      end else begin
        base = 4 * int'(HUE_SIXTH);
        num = r - g;
      end
      // round half away from zero on the magnitude
      q = (2 * int'(HUE_SIXTH) * (num < 0 ? -num : num) + delta) / (2 * delta);
      hue = base + (num < 0 ? -q : q);
    end
    if (hue < 0) hue += int'(HUE_FULL);
    if (hue >= int'(HUE_FULL)) hue -= int'(HUE_FULL);
    res.hue = HUE_W'(hue);
    res.saturation = (mx > 0) ? SAT_W'((2 * int'(SAT_ONE) * delta + mx) / (2 * mx)) : '0;
    res.brightness = CH_W'(mx);
    res.alpha = pix[31:24];
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [7:0] r, g, b, a;
    int         kind;
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    a = 8'($urandom_range(0, 255));
    kind = $urandom_range(0, 9);
    case (kind)
      6: begin
        g = r;
        b = r;
      end
      7: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      8: begin
        r = 8'($urandom_range(0, 3));
        g = 8'($urandom_range(0, 3));
        b = 8'($urandom_range(0, 3));
      end
      9: begin
        case ($urandom_range(0, 2))
          0: begin r = 8'hFF; g = 8'h00; end
          1: begin g = 8'hFF; b = 8'h00; end
          default: begin b = 8'hFF; r = 8'h00; end
        endcase
      end
      default: ;
    endcase
    return {a, b, g, r};
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d words still expected", cycles, hsv_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pix_q.size() > 0) begin
        in_tdata <= pix_q.pop_front();
        in_tvalid <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 39) == 0) calm = 50;
        in_gap = (hold_off || calm > 0) ? 0 : gap_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // output receiver
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (calm == 0 && $urandom_range(0, 4) == 0) rx_gap = gap_len();
    end
  end

  // input acceptance and output check
  always @(posedge clk) begin
    hsv_t exp;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hsv_q = {hsv_q, to_hsv(in_tdata)};
        pixels_in++;
        in_taken = 1'b1;
      end
      if (in_tvalid && !in_tready) stall_cycles++;
      if (out_tvalid && out_tready) begin
        words_out++;
        if (hsv_q.size() == 0) begin
          $error("unexpected output word %h", out_tdata);
          mismatches++;
        end else begin
          exp = hsv_q.pop_front();
          if (out_tdata[14:0] !== exp.hue) begin
            $error("hue: expected %0d, got %0d", exp.hue, out_tdata[14:0]);
            mismatches++;
          end
          if (out_tdata[27:15] !== exp.saturation) begin
            $error("saturation: expected %0d, got %0d", exp.saturation, out_tdata[27:15]);
            mismatches++;
          end
          if (out_tdata[35:28] !== exp.brightness) begin
            $error("brightness: expected %0d, got %0d", exp.brightness, out_tdata[35:28]);
            mismatches++;
          end
          if (out_tdata[43:36] !== exp.alpha) begin
            $error("alpha_out: expected %0d, got %0d", exp.alpha, out_tdata[43:36]);
            mismatches++;
          end
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and in_tready drops
  initial begin
    wait (pixels_in >= 150);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    // black, white, grey, primaries, ties, wrap-around, small max
    pix_q = {pix_q, {8'h00, 8'h00, 8'h00, 8'h00}};
    pix_q = {pix_q, {8'hFF, 8'hFF, 8'hFF, 8'hFF}};
    pix_q = {pix_q, {8'h11, 8'h80, 8'h80, 8'h80}};
    pix_q = {pix_q, {8'hAA, 8'h00, 8'h00, 8'hFF}};
    pix_q = {pix_q, {8'h55, 8'h00, 8'hFF, 8'h00}};
    pix_q = {pix_q, {8'h0F, 8'hFF, 8'h00, 8'h00}};
    pix_q = {pix_q, {8'hF0, 8'h00, 8'hFF, 8'hFF}};
    pix_q = {pix_q, {8'h01, 8'hFF, 8'hFF, 8'h00}};
    pix_q = {pix_q, {8'h80, 8'hFF, 8'h00, 8'hFF}};
    pix_q = {pix_q, {8'h7F, 8'h01, 8'h00, 8'hFF}};
    pix_q = {pix_q, {8'hFE, 8'h00, 8'h01, 8'hFF}};
    pix_q = {pix_q, {8'h33, 8'h00, 8'h00, 8'h01}};
    pix_q = {pix_q, {8'hCC, 8'hFE, 8'hFE, 8'hFF}};
    pix_q = {pix_q, {8'h3C, 8'hFF, 8'h01, 8'h00}};
    pix_q = {pix_q, {8'hC3, 8'h96, 8'h64, 8'hC8}};
    pix_q = {pix_q, {8'h5A, 8'h00, 8'h01, 8'h01}};
    pix_q = {pix_q, {8'hA5, 8'h01, 8'h01, 8'h00}};
    pix_q = {pix_q, {8'h69, 8'h01, 8'h00, 8'h01}};
    pix_q = {pix_q, {8'h96, 8'h00, 8'h80, 8'hFF}};
    pix_q = {pix_q, {8'h00, 8'h5B, 8'hC8, 8'h25}};
    pix_q = {pix_q, {8'hFF, 8'hFF, 8'h00, 8'h01}};
    directed_cnt = pix_q.size();
    repeat (RAND_PIXELS) pix_q = {pix_q, rand_pixel()};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pix_q.size() == 0 && !in_tvalid);
    wait (hsv_q.size() == 0);
    repeat (40) @(posedge clk);

    $display("Converted %0d pixels (%0d directed, %0d random) into %0d HSV words.",
             pixels_in, directed_cnt, RAND_PIXELS, words_out);
    $display("Input was held off by backpressure for %0d cycles; %0d field mismatches.",
             stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: rgb_to_hsv_converter.f
design/rhc_pkg.sv
design/rhc_front.sv
design/rhc_div.sv
design/rhc_back.sv
design/rgb_to_hsv_converter.sv
dv/tb_rgb_to_hsv_converter.sv
